FILE: hw/rtl/ddrc_pkg.sv
// ddrc_pkg: shared types, codes and constants of the differential drive controller
// used by ddrc_nav, ddrc_balance and diff_drive_rotate_drive_controller_core
// no dependencies
package ddrc_pkg;

   // drive directions; NONE marks a baseline that matches no direction
   typedef enum logic [2:0] {
      DIR_FORWARD  = 3'd0,
      DIR_BACKWARD = 3'd1,
      DIR_RIGHT    = 3'd2,
      DIR_LEFT     = 3'd3,
      DIR_STOP     = 3'd4,
      DIR_NONE     = 3'd7
   } dir_type;

   // wheel brake codes
   typedef enum logic [1:0] {
      BRAKE_NONE  = 2'd0,
      BRAKE_RIGHT = 2'd1,
      BRAKE_LEFT  = 2'd2
   } brake_type;

   // arrival message kinds
   typedef enum logic [1:0] {
      MSG_NONE  = 2'd0,
      MSG_LINK  = 2'd1,
      MSG_SHORT = 2'd2
   } msg_type;

   // step commands
   localparam logic CMD_ROTATE = 1'b0;
   localparam logic CMD_DRIVE  = 1'b1;

   // csr register indexes
   localparam logic [1:0] CSR_TICK_TOLERANCE = 2'd0;
   localparam logic [1:0] CSR_DEAD_ZONE      = 2'd1;
   localparam logic [1:0] CSR_MESSAGE_MODE   = 2'd2;

   // csr reset values
   localparam logic [14:0] TICK_TOLERANCE_RESET = 15'd1;
   localparam logic [11:0] DEAD_ZONE_RESET      = 12'd143;
   localparam logic        MESSAGE_MODE_RESET   = 1'b0;

   // navigation status codes
   localparam logic [7:0] STATUS_DONE      = 8'd1;
   localparam logic [7:0] STATUS_TURN_WAIT = 8'd3;
   localparam logic [7:0] STATUS_TURN_DONE = 8'd4;

   // fixed point: heading units of two degrees to Q4.12 radians (Q22 scale)
   localparam int unsigned RAD_PER_UNIT_Q22 = 146409;
   localparam int unsigned RAD_ROUND        = 512;
   localparam int unsigned RAD_SHIFT        = 10;
   localparam int          PI_Q12           = 12868;

   // default encoder counter width
   localparam int unsigned TICK_BITS_DEFAULT = 16;

   // request from the navigation logic to the wheel balance logic
   typedef struct packed {
      logic       en;
      dir_type    dir;
      logic [7:0] status;
   } bal_req_type;

endpackage

FILE: hw/rtl/ddrc_balance.sv
// ddrc_balance: wheel balance logic with tick baselines and brake decision
// depends on ddrc_pkg
module ddrc_balance #(
   parameter int unsigned TICK_BITS = ddrc_pkg::TICK_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ddrc_pkg::bal_req_type bal_req,
   input  logic [15:0]           left_ticks,
   input  logic [15:0]           right_ticks,
   input  logic [14:0]           tick_tolerance,
   output ddrc_pkg::brake_type   brake_command
);

   // compare width: holds a negated tick lead plus the tolerance without wrap
   localparam int unsigned CW = ((TICK_BITS > 16) ? TICK_BITS : 16) + 2;

   ddrc_pkg::dir_type      last_dir_ff, last_dir_in;
   logic [7:0]             last_status_ff, last_status_in;
   logic [TICK_BITS-1:0]   base_left_ff, base_left_in;
   logic [TICK_BITS-1:0]   base_right_ff, base_right_in;

   logic [TICK_BITS-1:0]   lt, rt;
   logic [TICK_BITS-1:0]   dl, dr;
   logic                   changed;
   logic signed [CW-1:0]   tl, tr, tol, x, y;

   // ticks modulo the counter width
   assign lt = TICK_BITS'(left_ticks);
   assign rt = TICK_BITS'(right_ticks);

   // a new direction or status restarts the baseline at the current ticks
   assign changed = (bal_req.dir != last_dir_ff) || (bal_req.status != last_status_ff);

   // signed tick counts since the baseline
   always_comb begin
      dl  = changed ? '0 : (lt - base_left_ff);
      dr  = changed ? '0 : (rt - base_right_ff);
      tl  = CW'($signed(dl));
      tr  = CW'($signed(dr));
      tol = $signed(CW'(tick_tolerance));
   end

   // lead of one wheel over the other, oriented by direction
   always_comb begin
      x = '0;
      y = '0;
      unique case (bal_req.dir)
         ddrc_pkg::DIR_FORWARD: begin
            x = tr;
            y = tl;
         end
         ddrc_pkg::DIR_BACKWARD: begin
            x = tl;
            y = tr;
         end
         ddrc_pkg::DIR_RIGHT: begin
            x = -tr;
            y = tl;
         end
         ddrc_pkg::DIR_LEFT: begin
            x = tr;
            y = -tl;
         end
         default: begin
            x = '0;
            y = '0;
         end
      endcase
   end

   // brake the wheel that is ahead by more than the tolerance
   always_comb begin
      brake_command = ddrc_pkg::BRAKE_NONE;
      if (bal_req.en) begin
         priority if (x > y + tol) brake_command = ddrc_pkg::BRAKE_RIGHT;
         else if (y > x + tol)     brake_command = ddrc_pkg::BRAKE_LEFT;
         else                      brake_command = ddrc_pkg::BRAKE_NONE;
      end
   end

   // baseline update on a committed step that uses the balance logic
   always_comb begin
      last_dir_in    = last_dir_ff;
      last_status_in = last_status_ff;
      base_left_in   = base_left_ff;
      base_right_in  = base_right_ff;
      if (fire && bal_req.en && changed) begin
         last_dir_in    = bal_req.dir;
         last_status_in = bal_req.status;
         base_left_in   = lt;
         base_right_in  = rt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff    <= ddrc_pkg::DIR_NONE;
         last_status_ff <= '0;
         base_left_ff   <= '0;
         base_right_ff  <= '0;
      end else begin
         last_dir_ff    <= last_dir_in;
         last_status_ff <= last_status_in;
         base_left_ff   <= base_left_in;
         base_right_ff  <= base_right_in;
      end
   end

endmodule

FILE: hw/rtl/ddrc_nav.sv
// ddrc_nav: rotate and drive step decisions with the drive start point state
// depends on ddrc_pkg
module ddrc_nav (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  cmd,
   input  logic [7:0]            target_heading,
   input  logic signed [7:0]     target_distance,
   input  logic signed [15:0]    robot_x,
   input  logic signed [15:0]    robot_y,
   input  logic signed [16:0]    robot_heading,
   input  logic [7:0]            mode_status,
   input  logic [11:0]           dead_zone,
   input  logic                  message_mode,
   output ddrc_pkg::dir_type     drive_command,
   output logic [7:0]            new_status,
   output logic                  arrived,
   output ddrc_pkg::msg_type     message_kind,
   output ddrc_pkg::bal_req_type bal_req,
   output logic                  drive_active
);

   logic                phase_ff, phase_in;
   logic signed [15:0]  start_x_ff, start_x_in;
   logic signed [15:0]  start_y_ff, start_y_in;

   logic [25:0]         tgt_prod;
   logic signed [19:0]  tgt, hd, dz, diff;
   logic signed [16:0]  dx, dy;
   logic signed [33:0]  dx_sq, dy_sq;
   logic [34:0]         dist2;
   logic signed [15:0]  td_sq;
   logic [20:0]         tgt2;
   logic [20:0]         td_sq_u;

   // target heading in Q4.12 radians, rounded
   assign tgt_prod = 26'(target_heading) * 26'(ddrc_pkg::RAD_PER_UNIT_Q22)
                   + 26'(ddrc_pkg::RAD_ROUND);
   assign tgt  = $signed({4'b0, tgt_prod[25:ddrc_pkg::RAD_SHIFT]});
   assign hd   = 20'(robot_heading);
   assign dz   = $signed({8'b0, dead_zone});
   assign diff = tgt - hd;

   // squared travel since the start point and squared target in mm
   assign dx      = 17'(start_x_ff) - 17'(robot_x);
   assign dy      = 17'(start_y_ff) - 17'(robot_y);
   assign dx_sq   = dx * dx;
   assign dy_sq   = dy * dy;
   assign dist2   = 35'($unsigned(dx_sq)) + 35'($unsigned(dy_sq));
   assign td_sq   = target_distance * target_distance;
   assign td_sq_u = 21'($unsigned(td_sq));
   // times 100 as 64 + 32 + 4
   assign tgt2    = (td_sq_u << 6) + (td_sq_u << 5) + (td_sq_u << 2);

   // step decision
   always_comb begin
      drive_command = ddrc_pkg::DIR_STOP;
      new_status    = mode_status;
      arrived       = 1'b0;
      message_kind  = ddrc_pkg::MSG_NONE;
      phase_in      = phase_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      if (cmd == ddrc_pkg::CMD_ROTATE) begin
         priority if (diff > 20'(ddrc_pkg::PI_Q12))  drive_command = ddrc_pkg::DIR_RIGHT;
         else if (diff < -20'(ddrc_pkg::PI_Q12))     drive_command = ddrc_pkg::DIR_LEFT;
         else if (tgt + dz < hd)                     drive_command = ddrc_pkg::DIR_RIGHT;
         else if (tgt - dz > hd)                     drive_command = ddrc_pkg::DIR_LEFT;
         else begin
            new_status = (mode_status == ddrc_pkg::STATUS_TURN_WAIT) ?
                         ddrc_pkg::STATUS_TURN_DONE : ddrc_pkg::STATUS_DONE;
         end
      end else if (!phase_ff) begin
         // idle: start a run unless the distance is zero
         if (target_distance != 8'sd0) begin
            start_x_in    = robot_x;
            start_y_in    = robot_y;
            phase_in      = 1'b1;
            drive_command = ddrc_pkg::DIR_FORWARD;
         end else begin
            new_status = ddrc_pkg::STATUS_DONE;
         end
      end else begin
         // running: stop once the travelled distance reaches the target
         if (35'(tgt2) <= dist2) begin
            new_status   = ddrc_pkg::STATUS_DONE;
            phase_in     = 1'b0;
            arrived      = 1'b1;
            message_kind = message_mode ? ddrc_pkg::MSG_SHORT : ddrc_pkg::MSG_LINK;
         end else begin
            drive_command = ddrc_pkg::DIR_FORWARD;
         end
      end
   end

   // every moving command goes through the wheel balance
   assign bal_req.en     = (drive_command != ddrc_pkg::DIR_STOP);
   assign bal_req.dir    = drive_command;
   assign bal_req.status = mode_status;
   assign drive_active   = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
      end
   end

endmodule

FILE: hw/rtl/diff_drive_rotate_drive_controller_core.sv
// diff_drive_rotate_drive_controller_core: top level of the navigation controller
// instantiates ddrc_nav and ddrc_balance, uses ddrc_pkg
//
//   channel | dir | beat                         | handshake
//   req_    | in  | one control tick             | req_tvalid / req_tready
//   rsp_    | out | drive, brake and status      | rsp_tvalid / rsp_tready
//   csr_    | in  | register index and data      | csr_valid / csr_ready
//
// a beat is taken into the input register, then decided into the result register
// by the single decision stage that also updates the state; one beat per cycle
// sustained while the result is not stalled
// reset is synchronous; it clears valid flags, drive phase and tick baselines
// a stalled result holds its register; a new beat still enters the input
// register while the result waits, and further input stalls after that
// csr_ready is always high; writes land in the next cycle
module diff_drive_rotate_drive_controller_core #(
   parameter int unsigned TICK_BITS = ddrc_pkg::TICK_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // target_heading[7:0], target_distance[15:8], robot_x[31:16], robot_y[47:32],
   // robot_heading[64:48], left_ticks[80:65], right_ticks[96:81],
   // mode_status[104:97], zero fill[111:105]
   input  logic [111:0] req_tdata,
   // cmd[0]
   input  logic [0:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // drive_command[2:0], brake_command[4:3], new_status[12:5], arrived[13],
   // zero fill[15:14]
   output logic [15:0]  rsp_tdata,
   // message_kind[1:0]
   output logic [1:0]   rsp_tuser,
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [14:0]  csr_data
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [111:0]          s1_data_ff;
   logic                  s1_cmd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_data_ff;
   logic [1:0]            rsp_user_ff;
   logic                  advance;
   logic                  req_fire;

   logic [14:0]           tick_tolerance_ff;
   logic [11:0]           dead_zone_ff;
   logic                  message_mode_ff;

   ddrc_pkg::dir_type     drive_command;
   ddrc_pkg::brake_type   brake_command;
   ddrc_pkg::msg_type     message_kind;
   ddrc_pkg::bal_req_type bal_req;
   logic [7:0]            new_status;
   logic                  arrived;
   logic                  drive_active;

   // handshake
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_tolerance_ff <= ddrc_pkg::TICK_TOLERANCE_RESET;
         dead_zone_ff      <= ddrc_pkg::DEAD_ZONE_RESET;
         message_mode_ff   <= ddrc_pkg::MESSAGE_MODE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ddrc_pkg::CSR_TICK_TOLERANCE: tick_tolerance_ff <= csr_data;
            ddrc_pkg::CSR_DEAD_ZONE:      dead_zone_ff      <= csr_data[11:0];
            ddrc_pkg::CSR_MESSAGE_MODE:   message_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input register
   assign s1_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_tdata;
         s1_cmd_ff  <= req_tuser[0];
      end
   end

   // step decision
   ddrc_nav u_nav (
      .clock           (clock),
      .reset           (reset),
      .fire            (advance),
      .cmd             (s1_cmd_ff),
      .target_heading  (s1_data_ff[7:0]),
      .target_distance ($signed(s1_data_ff[15:8])),
      .robot_x         ($signed(s1_data_ff[31:16])),
      .robot_y         ($signed(s1_data_ff[47:32])),
      .robot_heading   ($signed(s1_data_ff[64:48])),
      .mode_status     (s1_data_ff[104:97]),
      .dead_zone       (dead_zone_ff),
      .message_mode    (message_mode_ff),
      .drive_command   (drive_command),
      .new_status      (new_status),
      .arrived         (arrived),
      .message_kind    (message_kind),
      .bal_req         (bal_req),
      .drive_active    (drive_active)
   );

   // wheel balance
   ddrc_balance #(
      .TICK_BITS (TICK_BITS)
   ) u_balance (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .bal_req        (bal_req),
      .left_ticks     (s1_data_ff[80:65]),
      .right_ticks    (s1_data_ff[96:81]),
      .tick_tolerance (tick_tolerance_ff),
      .brake_command  (brake_command)
   );

   // result register
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, arrived, new_status, brake_command, drive_command};
         rsp_user_ff <= message_kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTH
   // an arrival beat stops, releases the brakes and names a message kind
   a_arrival_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |->
         rsp_tdata[2:0] == ddrc_pkg::DIR_STOP && rsp_tdata[4:3] == ddrc_pkg::BRAKE_NONE &&
         rsp_tuser != ddrc_pkg::MSG_NONE)
      else $error("arrival beat without stop or message kind");

   // brakes act only on a moving command
   a_brake_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:3] != ddrc_pkg::BRAKE_NONE |->
         rsp_tdata[2:0] != ddrc_pkg::DIR_STOP)
      else $error("brake on a stopped command");

   // a drive run starts only through a committed drive step
   a_phase_start: assert property (@(posedge clock) disable iff (reset)
      $rose(drive_active) |-> $past(advance) && $past(s1_cmd_ff) == ddrc_pkg::CMD_DRIVE)
      else $error("drive phase started without a drive step");

   // input stalls only while a beat is held behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_tvalid && !rsp_tready)
      else $error("input stalled without a held result");
`endif

endmodule
